@@ src/bms_pkg.sv @@
// Package with the shared types and constants of the buzzer melody sequencer.
`default_nettype none

package bms_pkg;

    // Field widths.
    localparam int FUNC_W  = 3;
    localparam int TRACK_W = 3;
    localparam int IDX_W   = 8;
    localparam int FREQ_W  = 16;
    localparam int DUR_W   = 8;
    localparam int CNT_W   = 8;
    localparam int TEMPO_W = 8;
    localparam int PAUSE_W = 8;
    localparam int TLIM_W  = 4;
    localparam int TIMER_W = 16;
    localparam int MODE_W  = 2;
    localparam int ENTRY_W = FREQ_W + DUR_W;
    localparam int HDR_W   = CNT_W + TEMPO_W;

    // Item function codes.
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PLAY     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_WR_NOTE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_WR_HDR   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ALIVE    = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_PAUSE_TICKS  = 2'd0;
    localparam logic [1:0] REG_MAX_PLAY     = 2'd1;
    localparam logic [1:0] REG_TRACK_LIMIT  = 2'd2;
    localparam logic [1:0] REG_STARTUP_SONG = 2'd3;

    // Configuration reset values.
    localparam logic [PAUSE_W-1:0] PAUSE_TICKS_RST  = 8'd1;
    localparam logic [CNT_W-1:0]   MAX_PLAY_RST     = 8'd255;
    localparam logic [TLIM_W-1:0]  TRACK_LIMIT_RST  = 4'd8;
    localparam logic               STARTUP_SONG_RST = 1'b0;

    typedef struct packed {
        logic [PAUSE_W-1:0] pause_ticks;
        logic [CNT_W-1:0]   max_play;
        logic [TLIM_W-1:0]  track_limit;
        logic               startup_song;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [TRACK_W-1:0] track;
        logic [IDX_W-1:0]   note_index;
        logic [FREQ_W-1:0]  frequency;
        logic [DUR_W-1:0]   duration;
        logic [CNT_W-1:0]   note_count;
        logic [TEMPO_W-1:0] tempo;
    } item_t;

    typedef struct packed {
        logic [FREQ_W-1:0] tone_frequency;
        logic              tone_on;
        logic [MODE_W-1:0] mode;
    } result_t;

endpackage

`default_nettype wire

@@ src/buzzer_melody_sequencer_core.sv @@
// Top level of the buzzer melody sequencer: stream ports, result register, APB port.
//
//  Channel   Ports                        Direction  Contents
//  input     s_tvalid/s_tready/s_t*       in         one command word per item
//  result    m_tvalid/m_tready/m_tdata    out        buzzer tone and mode per item
//  config    psel/penable/pwrite/paddr..  in         four control registers
//
// A word is taken in every cycle that the result register is empty or being
// emptied, so the block sustains one word per clock. Each word then sits in
// the item register, where the note table has already been read for it, and
// its result is loaded into the result register when it leaves that stage.
// The note table is read on the edge that accepts the word, at addresses
// derived from the player state the previous word leaves behind, so the
// registered table read sets the depth. Reset is synchronous, active low,
// clears the player state, the track headers and the valid flags and loads
// the configuration reset values; the note table is not cleared. A stall on
// the result side holds both stages and drops s_tready in the same cycle.
`default_nettype none

module buzzer_melody_sequencer_core #(
    parameter int TRACKS          = 8,
    parameter int NOTES_PER_TRACK = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0 up: track[2:0], note_index[10:3], frequency[26:11],
    // duration[34:27], note_count[42:35], tempo[50:43], zero fill [55:51].
    input  wire logic [55:0] s_tdata,
    // Fields from bit 0 up: func[2:0].
    input  wire logic [2:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0 up: tone_frequency[15:0], tone_on[16], mode[18:17],
    // zero fill [23:19].
    output logic      [23:0] m_tdata,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import bms_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    result_t result;
    logic    adv;
    logic    item_valid;
    logic    m_valid_reg;
    result_t m_data_reg;

    // The pipeline moves whenever the result register can take a word.
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign pready   = 1'b1;

    assign in_item.func       = s_tuser;
    assign in_item.track      = s_tdata[2:0];
    assign in_item.note_index = s_tdata[10:3];
    assign in_item.frequency  = s_tdata[26:11];
    assign in_item.duration   = s_tdata[34:27];
    assign in_item.note_count = s_tdata[42:35];
    assign in_item.tempo      = s_tdata[50:43];

    bms_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    bms_engine #(
        .TRACKS          (TRACKS),
        .NOTES_PER_TRACK (NOTES_PER_TRACK)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .in_item    (in_item),
        .cfg        (cfg),
        .item_valid (item_valid),
        .result     (result)
    );

    // Result register: loaded when the processed word leaves the item stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= item_valid;
        end
        if (adv && item_valid) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_data_reg.mode, m_data_reg.tone_on, m_data_reg.tone_frequency};

endmodule

`default_nettype wire

@@ src/bms_note_mem.sv @@
// Note table memory: one write port and two registered read ports.
`default_nettype none

module bms_note_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  wire logic                        aclk,
    input  wire logic                        we,
    input  wire logic [ADDR_W-1:0]           waddr,
    input  wire logic [bms_pkg::ENTRY_W-1:0] wdata,
    input  wire logic                        re,
    input  wire logic [ADDR_W-1:0]           raddr_a,
    input  wire logic [ADDR_W-1:0]           raddr_b,
    output logic      [bms_pkg::ENTRY_W-1:0] rdata_a,
    output logic      [bms_pkg::ENTRY_W-1:0] rdata_b
);
    import bms_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

@@ src/bms_cfg_regs.sv @@
// Configuration register bank behind the APB-style port.
`default_nettype none

module bms_cfg_regs (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output bms_pkg::cfg_t    cfg
);
    import bms_pkg::*;

    logic [PAUSE_W-1:0] pause_ticks_reg;
    logic [CNT_W-1:0]   max_play_reg;
    logic [TLIM_W-1:0]  track_limit_reg;
    logic               startup_song_reg;
    logic               wr_en;
    logic [1:0]         reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pause_ticks_reg  <= PAUSE_TICKS_RST;
            max_play_reg     <= MAX_PLAY_RST;
            track_limit_reg  <= TRACK_LIMIT_RST;
            startup_song_reg <= STARTUP_SONG_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PAUSE_TICKS:  pause_ticks_reg  <= pwdata[PAUSE_W-1:0];
                REG_MAX_PLAY:     max_play_reg     <= pwdata[CNT_W-1:0];
                REG_TRACK_LIMIT:  track_limit_reg  <= pwdata[TLIM_W-1:0];
                REG_STARTUP_SONG: startup_song_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_PAUSE_TICKS:  prdata = {{(32-PAUSE_W){1'b0}}, pause_ticks_reg};
            REG_MAX_PLAY:     prdata = {{(32-CNT_W){1'b0}}, max_play_reg};
            REG_TRACK_LIMIT:  prdata = {{(32-TLIM_W){1'b0}}, track_limit_reg};
            REG_STARTUP_SONG: prdata = {31'b0, startup_song_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.pause_ticks  = pause_ticks_reg;
    assign cfg.max_play     = max_play_reg;
    assign cfg.track_limit  = track_limit_reg;
    assign cfg.startup_song = startup_song_reg;

endmodule

`default_nettype wire

@@ src/bms_engine.sv @@
// Sequencer engine: item register, player state, track headers and note table.
`default_nettype none

module bms_engine #(
    parameter int TRACKS          = 8,
    parameter int NOTES_PER_TRACK = 256
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           adv,
    input  wire logic           in_valid,
    input  wire bms_pkg::item_t in_item,
    input  wire bms_pkg::cfg_t  cfg,
    output logic                item_valid,
    output bms_pkg::result_t    result
);
    import bms_pkg::*;

    localparam int DEPTH  = TRACKS * NOTES_PER_TRACK;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TSEL_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT    = 2'd0,
        MODE_STANDBY = 2'd1,
        MODE_PLAYING = 2'd2
    } mode_t;

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [TRACK_W-1:0] trk,
                                                     input logic [IDX_W-1:0]   pos);
        entry_addr = ADDR_W'(int'(trk) * NOTES_PER_TRACK + int'(pos));
    endfunction

    // Player state.
    mode_t               mode_reg, mode_next;
    logic [TRACK_W-1:0]  cur_track_reg, cur_track_next;
    logic [CNT_W-1:0]    note_limit_reg, note_limit_next;
    logic [IDX_W-1:0]    note_pos_reg, note_pos_next;
    logic [TIMER_W-1:0]  note_timer_reg, note_timer_next;
    logic                note_started_reg, note_started_next;
    logic [PAUSE_W-1:0]  pause_count_reg, pause_count_next;
    logic [FREQ_W-1:0]   tone_freq_reg, tone_freq_next;
    logic                tone_on_reg, tone_on_next;
    logic [HDR_W-1:0]    hdr_reg [TRACKS];

    // Item register and read bypass.
    item_t               item_reg;
    logic                item_valid_reg;
    logic                fwd_a_reg, fwd_b_reg;
    logic [ENTRY_W-1:0]  fwd_word_reg;

    logic                fire, accept;
    logic [ENTRY_W-1:0]  rdata_a, rdata_b;
    logic [FREQ_W-1:0]   freq_a;
    logic [DUR_W-1:0]    dur_b;
    logic [TRACK_W-1:0]  hdr_trk;
    logic [HDR_W-1:0]    hdr_word;
    logic                trk_ok;
    logic [CNT_W-1:0]    lim_sel;
    logic [TIMER_W-1:0]  note_time;
    logic [IDX_W-1:0]    pos_inc;
    logic                do_start;
    logic                hdr_we;
    logic                note_we;
    logic [ADDR_W-1:0]   note_waddr;
    logic [ENTRY_W-1:0]  note_wdata;
    logic [ADDR_W-1:0]   raddr_a, raddr_b;

    assign fire   = item_valid_reg && adv;
    assign accept = in_valid && adv;

    assign freq_a = fwd_a_reg ? fwd_word_reg[ENTRY_W-1:DUR_W] : rdata_a[ENTRY_W-1:DUR_W];
    assign dur_b  = fwd_b_reg ? fwd_word_reg[DUR_W-1:0] : rdata_b[DUR_W-1:0];

    // Header lookup: the requested track on a play request, track 0 on go-alive, the playing track otherwise.
    always_comb begin
        if (item_reg.func == FUNC_PLAY) begin
            hdr_trk = item_reg.track;
        end else if (item_reg.func == FUNC_ALIVE) begin
            hdr_trk = '0;
        end else begin
            hdr_trk = cur_track_reg;
        end
    end

    assign hdr_word  = hdr_reg[TSEL_W'(hdr_trk)];
    assign trk_ok    = ({1'b0, hdr_trk} < cfg.track_limit) && (int'(hdr_trk) < TRACKS);
    assign note_time = {8'b0, dur_b} * {8'b0, hdr_word[TEMPO_W-1:0]};
    assign pos_inc   = note_pos_reg + 8'd1;

    always_comb begin
        if (hdr_word[HDR_W-1:TEMPO_W] < cfg.max_play) begin
            lim_sel = hdr_word[HDR_W-1:TEMPO_W];
        end else begin
            lim_sel = cfg.max_play;
        end
        if (int'(lim_sel) > NOTES_PER_TRACK) begin
            lim_sel = CNT_W'(NOTES_PER_TRACK);
        end
    end

    // Table writes.
    assign note_we    = fire && (item_reg.func == FUNC_WR_NOTE) &&
                        (int'(item_reg.track) < TRACKS) &&
                        (int'(item_reg.note_index) < NOTES_PER_TRACK);
    assign note_waddr = entry_addr(item_reg.track, item_reg.note_index);
    assign note_wdata = {item_reg.frequency, item_reg.duration};
    assign hdr_we     = fire && (item_reg.func == FUNC_WR_HDR) &&
                        (int'(item_reg.track) < TRACKS);

    // Item processing.
    always_comb begin
        mode_next         = mode_reg;
        cur_track_next    = cur_track_reg;
        note_limit_next   = note_limit_reg;
        note_pos_next     = note_pos_reg;
        note_timer_next   = note_timer_reg;
        note_started_next = note_started_reg;
        pause_count_next  = pause_count_reg;
        tone_freq_next    = tone_freq_reg;
        tone_on_next      = tone_on_reg;
        do_start          = 1'b0;

        if (fire) begin
            case (item_reg.func)
                FUNC_TICK: begin
                    if (mode_reg == MODE_PLAYING) begin
                        if (note_pos_reg >= note_limit_reg) begin
                            mode_next      = MODE_STANDBY;
                            tone_freq_next = '0;
                            tone_on_next   = 1'b0;
                        end else if (!note_started_reg) begin
                            tone_freq_next    = freq_a;
                            tone_on_next      = (freq_a != '0);
                            note_started_next = 1'b1;
                            if (note_timer_reg != '0) begin
                                note_timer_next = note_timer_reg - 16'd1;
                            end
                        end else if (note_timer_reg != '0) begin
                            note_timer_next = note_timer_reg - 16'd1;
                        end else if (pause_count_reg < cfg.pause_ticks) begin
                            tone_freq_next   = '0;
                            tone_on_next     = 1'b0;
                            pause_count_next = pause_count_reg + 8'd1;
                        end else begin
                            pause_count_next  = '0;
                            note_started_next = 1'b0;
                            note_pos_next     = pos_inc;
                            note_timer_next   = (pos_inc < note_limit_reg) ? note_time : '0;
                        end
                    end
                end
                FUNC_PLAY: begin
                    if (mode_reg == MODE_PLAYING) begin
                        tone_freq_next = '0;
                        tone_on_next   = 1'b0;
                    end
                    if (mode_reg == MODE_STANDBY || mode_reg == MODE_PLAYING) begin
                        do_start = trk_ok;
                    end
                end
                FUNC_ALIVE: begin
                    if (mode_reg == MODE_INIT) begin
                        mode_next = MODE_STANDBY;
                        do_start  = cfg.startup_song && trk_ok;
                    end
                end
                default: ;
            endcase

            if (do_start) begin
                mode_next         = MODE_PLAYING;
                cur_track_next    = hdr_trk;
                note_limit_next   = lim_sel;
                note_pos_next     = '0;
                note_timer_next   = note_time;
                note_started_next = 1'b0;
                pause_count_next  = '0;
            end
        end
    end

    // Read addresses for the arriving word, taken from the state it will see.
    // Port A serves the note being sounded, port B the duration of a note
    // about to be loaded.
    assign raddr_a = entry_addr(cur_track_next, note_pos_next);

    always_comb begin
        if (in_item.func == FUNC_PLAY) begin
            raddr_b = entry_addr(in_item.track, '0);
        end else if (in_item.func == FUNC_ALIVE) begin
            raddr_b = entry_addr('0, '0);
        end else begin
            raddr_b = entry_addr(cur_track_next, note_pos_next + 8'd1);
        end
    end

    bms_note_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_note_mem (
        .aclk    (aclk),
        .we      (note_we),
        .waddr   (note_waddr),
        .wdata   (note_wdata),
        .re      (accept),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_INIT;
            cur_track_reg    <= '0;
            note_limit_reg   <= '0;
            note_pos_reg     <= '0;
            note_timer_reg   <= '0;
            note_started_reg <= 1'b0;
            pause_count_reg  <= '0;
            tone_freq_reg    <= '0;
            tone_on_reg      <= 1'b0;
            item_valid_reg   <= 1'b0;
            for (int i = 0; i < TRACKS; i++) begin
                hdr_reg[i] <= '0;
            end
        end else begin
            mode_reg         <= mode_next;
            cur_track_reg    <= cur_track_next;
            note_limit_reg   <= note_limit_next;
            note_pos_reg     <= note_pos_next;
            note_timer_reg   <= note_timer_next;
            note_started_reg <= note_started_next;
            pause_count_reg  <= pause_count_next;
            tone_freq_reg    <= tone_freq_next;
            tone_on_reg      <= tone_on_next;
            if (adv) begin
                item_valid_reg <= in_valid;
            end
            if (hdr_we) begin
                hdr_reg[TSEL_W'(item_reg.track)] <= {item_reg.note_count, item_reg.tempo};
            end
        end
        if (accept) begin
            item_reg     <= in_item;
            fwd_a_reg    <= note_we && (note_waddr == raddr_a);
            fwd_b_reg    <= note_we && (note_waddr == raddr_b);
            fwd_word_reg <= note_wdata;
        end
    end

    assign item_valid            = item_valid_reg;
    assign result.tone_frequency = tone_freq_next;
    assign result.tone_on        = tone_on_next;
    assign result.mode           = mode_next;

endmodule

`default_nettype wire

@@ sim/tb_buzzer_melody_sequencer_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the buzzer melody sequencer core: table-driven directed words, random songs and noise.

// How the bench works.
//
// Every input word makes exactly one result word, so the bench keeps a
// single queue of expected results. The queue is filled at the rising edge
// that accepts an input word. At that edge a behavioural copy of the player
// is stepped with the accepted word. The result side is checked at the rising
// edge that accepts a result word, field by field, against the oldest entry.
//
// The directed part is a short table walked by a loop. Rows whose outcome is
// obvious carry the expected result typed in. The other rows fall back on
// the behavioural copy. After that come five phases of random traffic, each
// with its own register setting and one of four idling patterns. Most of the
// random traffic is made of well-formed songs: a header write, the note
// writes, a play request and then enough ticks to finish the song. Some songs
// are cut short or overrun. Single noise words are mixed in.
//
// The note table has no reset, so the bench never lets the player read a note
// entry that has not been written. A play request for a valid track whose
// notes are not all known is turned into a tick.
module tb_buzzer_melody_sequencer_core;
    import bms_pkg::*;

    localparam int TRACKS         = 8;
    localparam int NOTES          = 256;
    localparam int DIR_ROWS       = 25;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_CAP      = 50;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;

    // Function codes that the block ignores.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT,
        MODE_STANDBY,
        MODE_PLAYING
    } mode_e;

    // One row of the directed table. The last three fields hold the expected
    // result, and they are used only where typed is set.
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [TRACK_W-1:0] track;
        logic [IDX_W-1:0]   idx;
        logic [FREQ_W-1:0]  freq;
        logic [DUR_W-1:0]   dur;
        logic [CNT_W-1:0]   cnt;
        logic [TEMPO_W-1:0] tempo;
        bit                 typed;
        logic [FREQ_W-1:0]  want_freq;
        bit                 want_on;
        mode_e              want_mode;
    } step_row_t;

    // A typed-in expectation that travels with its word until acceptance.
    typedef struct packed {
        bit      typed;
        result_t value;
    } pinned_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    buzzer_melody_sequencer_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    // Behavioural copy of the player. It starts in the reset state, because
    // reset is applied once at the very start of the run.
    cfg_t               cfg = '{PAUSE_TICKS_RST, MAX_PLAY_RST, TRACK_LIMIT_RST,
                                STARTUP_SONG_RST};
    mode_e              player_mode = MODE_INIT;
    logic [TRACK_W-1:0] play_track = '0;
    logic [CNT_W-1:0]   play_limit = '0;
    logic [IDX_W-1:0]   play_pos = '0;
    logic [TIMER_W-1:0] play_timer = '0;
    logic               play_started = 1'b0;
    logic [PAUSE_W-1:0] pause_done = '0;
    logic [FREQ_W-1:0]  tone_freq = '0;
    logic               tone_on = 1'b0;
    logic [ENTRY_W-1:0] note_table [0:TRACKS*NOTES-1];
    bit                 note_written [0:TRACKS*NOTES-1];
    logic [HDR_W-1:0]   header_table [0:TRACKS-1] = '{default: '0};

    result_t   expected_q [$];
    pinned_t   pinned_q [$];
    step_row_t directed_rows [DIR_ROWS];
    int        fails = 0;
    int        items_sent = 0;
    int        gap_pct = 0;
    int        stall_pct = 0;
    int        idle_cycles = 0;

    // Length of one note in ticks: duration units times the track's tempo.
    function automatic logic [TIMER_W-1:0] note_ticks(logic [TRACK_W-1:0] trk,
                                                      logic [IDX_W-1:0] pos);
        logic [TIMER_W-1:0] dur;
        logic [TIMER_W-1:0] tempo;
        dur   = TIMER_W'(note_table[{trk, pos}][DUR_W-1:0]);
        tempo = TIMER_W'(header_table[trk][TEMPO_W-1:0]);
        return dur * tempo;
    endfunction

    // A request for an invalid track is dropped here. A valid request loads
    // the first note and clears the pause counter and the started flag.
    function automatic void start_track(logic [TRACK_W-1:0] trk);
        logic [CNT_W-1:0] lim;
        if ({1'b0, trk} >= cfg.track_limit) return;
        lim = header_table[trk][HDR_W-1:TEMPO_W];
        if (lim > cfg.max_play) lim = cfg.max_play;
        play_track   = trk;
        play_limit   = lim;
        play_pos     = '0;
        play_timer   = note_ticks(trk, '0);
        play_started = 1'b0;
        pause_done   = '0;
        player_mode  = MODE_PLAYING;
    endfunction

    // One tick while playing does one of the following. It sounds a new note,
    // counts the note down, adds one silent tick, or moves to the next note.
    // When the last note is done it returns to standby.
    function automatic void tick_player();
        logic [FREQ_W-1:0] f;
        if (play_pos >= play_limit) begin
            player_mode = MODE_STANDBY;
            tone_freq   = '0;
            tone_on     = 1'b0;
        end else if (!play_started) begin
            f            = note_table[{play_track, play_pos}][ENTRY_W-1:DUR_W];
            tone_freq    = f;
            tone_on      = (f != '0);
            play_started = 1'b1;
            if (play_timer != '0) play_timer = play_timer - 1'b1;
        end else if (play_timer != '0) begin
            play_timer = play_timer - 1'b1;
        end else if (pause_done < cfg.pause_ticks) begin
            tone_freq  = '0;
            tone_on    = 1'b0;
            pause_done = pause_done + 1'b1;
        end else begin
            // A finished last note does not read the table: the timer is simply zero.
            pause_done   = '0;
            play_started = 1'b0;
            play_pos     = play_pos + 1'b1;
            play_timer   = (play_pos < play_limit) ? note_ticks(play_track, play_pos) : '0;
        end
    endfunction

    function automatic result_t melody_step(item_t w);
        result_t r;
        case (w.func)
            FUNC_TICK: begin
                if (player_mode == MODE_PLAYING) tick_player();
            end
            FUNC_PLAY: begin
                if (player_mode == MODE_STANDBY) begin
                    start_track(w.track);
                end else if (player_mode == MODE_PLAYING) begin
                    // The tone is cut even when the request itself is rejected.
                    tone_freq = '0;
                    tone_on   = 1'b0;
                    start_track(w.track);
                end
            end
            FUNC_WR_NOTE: begin
                note_table[{w.track, w.note_index}]   = {w.frequency, w.duration};
                note_written[{w.track, w.note_index}] = 1'b1;
            end
            FUNC_WR_HDR: begin
                header_table[w.track] = {w.note_count, w.tempo};
            end
            FUNC_ALIVE: begin
                if (player_mode == MODE_INIT) begin
                    player_mode = MODE_STANDBY;
                    if (cfg.startup_song) start_track('0);
                end
            end
            default: begin
            end
        endcase
        r.tone_frequency = tone_freq;
        r.tone_on        = tone_on;
        r.mode           = player_mode;
        return r;
    endfunction

    // A valid track is safe to start only when every note entry that the
    // player could read has been written. An invalid track is never read.
    function automatic bit track_ready(logic [TRACK_W-1:0] trk);
        int lim;
        if ({1'b0, trk} >= cfg.track_limit) return 1'b1;
        lim = header_table[trk][HDR_W-1:TEMPO_W];
        if (lim > cfg.max_play) lim = cfg.max_play;
        if (lim == 0) lim = 1;
        for (int i = 0; i < lim; i++) begin
            if (!note_written[int'(trk) * NOTES + i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic item_t random_word();
        item_t w;
        w.func       = $urandom_range(0, 7);
        w.track      = $urandom_range(0, TRACKS - 1);
        w.note_index = $urandom_range(0, 255);
        w.frequency  = $urandom_range(0, 65535);
        w.duration   = $urandom_range(0, 255);
        w.note_count = $urandom_range(0, 255);
        w.tempo      = $urandom_range(0, 255);
        return w;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        fails++;
        if (fails <= PRINT_CAP) begin
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
    endtask

    // Entered and left at a falling edge. The word is held until it is accepted.
    task automatic send_word(item_t w, bit typed, result_t typed_value);
        pinned_t p;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        p.typed = typed;
        p.value = typed_value;
        pinned_q.push_back(p);
        s_tvalid <= 1'b1;
        s_tuser  <= w.func;
        s_tdata  <= {5'b0, w.tempo, w.note_count, w.duration, w.frequency,
                     w.note_index, w.track};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    // A random word of any function. A play request that could make the
    // player read unwritten notes is turned into a tick.
    task automatic send_noise();
        item_t w;
        w = random_word();
        if (w.func == FUNC_PLAY && !track_ready(w.track)) w.func = FUNC_TICK;
        send_word(w, 1'b0, '0);
    endtask

    // One well-formed song: a header, its notes, a play request and the ticks.
    // Most songs run to standby. Some are cut short and some get spare ticks,
    // and noise words fall between the ticks.
    task automatic play_song();
        item_t              w;
        logic [TRACK_W-1:0] trk;
        logic [TEMPO_W-1:0] tempo;
        logic [TIMER_W-1:0] span;
        int                 valid_tracks, count, notes, played, ticks, r, i;
        bit                 slow;
        valid_tracks = (cfg.track_limit > TRACKS) ? TRACKS : int'(cfg.track_limit);
        if (valid_tracks > 0 && $urandom_range(0, 99) < 85) begin
            trk = $urandom_range(0, valid_tracks - 1);
        end else begin
            trk = $urandom_range(0, TRACKS - 1);
        end
        r = $urandom_range(0, 99);
        count = (r < 10) ? 0 : (r < 80) ? $urandom_range(1, 5) : $urandom_range(6, 16);
        // A slow song has the largest tempo, so it is kept to a single note.
        slow  = ($urandom_range(0, 99) < 5);
        tempo = slow ? 8'd255 : TEMPO_W'($urandom_range(0, 3));
        if (slow && count > 1) count = 1;

        w = random_word();
        w.func       = FUNC_WR_HDR;
        w.track      = trk;
        w.note_count = count;
        w.tempo      = tempo;
        send_word(w, 1'b0, '0);

        notes  = (count > 0) ? count : 1;
        played = (count < cfg.max_play) ? count : int'(cfg.max_play);
        ticks  = 1;
        for (i = 0; i < notes; i++) begin
            w = random_word();
            w.func       = FUNC_WR_NOTE;
            w.track      = trk;
            w.note_index = i;
            r = $urandom_range(0, 99);
            if (r < 12) w.frequency = '0;
            else if (r < 18) w.frequency = '1;
            w.duration = slow ? DUR_W'($urandom_range(0, 1)) : DUR_W'($urandom_range(0, 3));
            send_word(w, 1'b0, '0);
            span = TIMER_W'(w.duration) * TIMER_W'(tempo);
            if (i < played) ticks += 2 + cfg.pause_ticks + ((span > 0) ? span - 1 : 0);
        end

        w = random_word();
        w.func  = FUNC_PLAY;
        w.track = trk;
        send_word(w, 1'b0, '0);

        r = $urandom_range(0, 99);
        if (r < 20) ticks = $urandom_range(0, ticks);
        else if (r < 30) ticks += $urandom_range(1, 4);
        for (i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 99) < 10) send_noise();
            w = random_word();
            w.func = FUNC_TICK;
            send_word(w, 1'b0, '0);
        end
    endtask

    // An APB write: a setup cycle and then an access cycle. The register is
    // taken at the rising edge of the access cycle, since pready is always high.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_PAUSE_TICKS:  cfg.pause_ticks  = value[PAUSE_W-1:0];
            REG_MAX_PLAY:     cfg.max_play     = value[CNT_W-1:0];
            REG_TRACK_LIMIT:  cfg.track_limit  = value[TLIM_W-1:0];
            REG_STARTUP_SONG: cfg.startup_song = value[0];
            default: begin
            end
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(int pause, int max_notes, int limit, int startup);
        write_reg(REG_PAUSE_TICKS, pause);
        write_reg(REG_MAX_PLAY, max_notes);
        write_reg(REG_TRACK_LIMIT, limit);
        write_reg(REG_STARTUP_SONG, startup);
    endtask

    // Registers change only when every result is in, with a short margin after it.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0 || pinned_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(int pause, int max_notes, int limit, int startup,
                             int tx_gap, int rx_stall, int n_items);
        int target;
        settle();
        configure(pause, max_notes, limit, startup);
        gap_pct   = tx_gap;
        stall_pct = rx_stall;
        target    = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 70) play_song();
            else send_noise();
        end
    endtask

    // The receiver stalls at random in the phases that ask for it.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Result check first, then the prediction for a word accepted at the same
    // edge. A result can never belong to a word taken at the same edge.
    always @(posedge aclk) begin
        result_t want;
        result_t predicted;
        item_t   w;
        pinned_t p;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result word with nothing expected", m_tdata, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata[15:0] !== want.tone_frequency)
                        report_mismatch("tone_frequency", m_tdata[15:0], want.tone_frequency);
                    if (m_tdata[16] !== want.tone_on)
                        report_mismatch("tone_on", m_tdata[16], want.tone_on);
                    if (m_tdata[18:17] !== want.mode)
                        report_mismatch("mode", m_tdata[18:17], want.mode);
                end
            end
            if (s_tvalid && s_tready) begin
                w.func       = s_tuser;
                w.track      = s_tdata[2:0];
                w.note_index = s_tdata[10:3];
                w.frequency  = s_tdata[26:11];
                w.duration   = s_tdata[34:27];
                w.note_count = s_tdata[42:35];
                w.tempo      = s_tdata[50:43];
                predicted = melody_step(w);
                p = (pinned_q.size() != 0) ? pinned_q.pop_front() : '0;
                expected_q.push_back(p.typed ? p.value : predicted);
            end
        end
    end

    // The watchdog ends the run after too long without any handshake.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        item_t   w;
        result_t want;
        int      row;

        // The directed table. Track 0 is the startup song: a note at full
        // frequency and then a silent note of zero length. Track 7 holds a
        // very long note, and a play request arrives while it is sounding.
        directed_rows = '{
            // Ticks, play requests and unused codes do nothing in init.
            '{FUNC_TICK,        3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b1, 16'h0000, 1'b0, MODE_INIT},
            '{FUNC_PLAY,        3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b1, 16'h0000, 1'b0, MODE_INIT},
            '{FUNC_UNUSED_LAST, 3'd7, 8'd255, 16'hFFFF, 8'd255, 8'd255, 8'd255,
              1'b1, 16'h0000, 1'b0, MODE_INIT},
            '{FUNC_WR_HDR,      3'd0, 8'd0,   16'h0000, 8'd0,   8'd2,   8'd1,
              1'b1, 16'h0000, 1'b0, MODE_INIT},
            '{FUNC_WR_NOTE,     3'd0, 8'd0,   16'hFFFF, 8'd2,   8'd0,   8'd0,
              1'b1, 16'h0000, 1'b0, MODE_INIT},
            '{FUNC_WR_NOTE,     3'd0, 8'd1,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b1, 16'h0000, 1'b0, MODE_INIT},
            // Going alive with the startup song set starts track 0 at once.
            // A second go-alive is ignored.
            '{FUNC_ALIVE,       3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b1, 16'h0000, 1'b0, MODE_PLAYING},
            '{FUNC_ALIVE,       3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b1, 16'h0000, 1'b0, MODE_PLAYING},
            // Two ticks of sound, one tick of pause, then the advance.
            '{FUNC_TICK,        3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b1, 16'hFFFF, 1'b1, MODE_PLAYING},
            '{FUNC_TICK,        3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b1, 16'hFFFF, 1'b1, MODE_PLAYING},
            '{FUNC_TICK,        3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b1, 16'h0000, 1'b0, MODE_PLAYING},
            '{FUNC_TICK,        3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b0, 16'h0000, 1'b0, MODE_PLAYING},
            // The silent note has zero length, and its timer must not wrap.
            '{FUNC_TICK,        3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b0, 16'h0000, 1'b0, MODE_PLAYING},
            '{FUNC_TICK,        3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b0, 16'h0000, 1'b0, MODE_PLAYING},
            '{FUNC_TICK,        3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b0, 16'h0000, 1'b0, MODE_PLAYING},
            '{FUNC_TICK,        3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b1, 16'h0000, 1'b0, MODE_STANDBY},
            '{FUNC_TICK,        3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b1, 16'h0000, 1'b0, MODE_STANDBY},
            '{FUNC_WR_NOTE,     3'd7, 8'd0,   16'h8001, 8'd255, 8'd0,   8'd0,
              1'b1, 16'h0000, 1'b0, MODE_STANDBY},
            '{FUNC_WR_NOTE,     3'd7, 8'd255, 16'h7FFE, 8'h80,  8'd0,   8'd0,
              1'b1, 16'h0000, 1'b0, MODE_STANDBY},
            '{FUNC_WR_HDR,      3'd7, 8'd0,   16'h0000, 8'd0,   8'd1,   8'd255,
              1'b1, 16'h0000, 1'b0, MODE_STANDBY},
            '{FUNC_PLAY,        3'd7, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b1, 16'h0000, 1'b0, MODE_PLAYING},
            '{FUNC_TICK,        3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b1, 16'h8001, 1'b1, MODE_PLAYING},
            // A play request while playing silences the tone and restarts on track 0.
            '{FUNC_PLAY,        3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b1, 16'h0000, 1'b0, MODE_PLAYING},
            '{FUNC_TICK,        3'd0, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
              1'b1, 16'hFFFF, 1'b1, MODE_PLAYING},
            '{FUNC_WR_HDR,      3'd6, 8'd0,   16'h0000, 8'd0,   8'd255, 8'd0,
              1'b0, 16'h0000, 1'b0, MODE_PLAYING}
        };

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The registers are set while the block is still in init, so that the
        // go-alive word in the table starts the startup song.
        configure(1, 255, 8, 1);
        for (row = 0; row < DIR_ROWS; row++) begin
            w.func       = directed_rows[row].func;
            w.track      = directed_rows[row].track;
            w.note_index = directed_rows[row].idx;
            w.frequency  = directed_rows[row].freq;
            w.duration   = directed_rows[row].dur;
            w.note_count = directed_rows[row].cnt;
            w.tempo      = directed_rows[row].tempo;
            want.tone_frequency = directed_rows[row].want_freq;
            want.tone_on        = directed_rows[row].want_on;
            want.mode           = directed_rows[row].want_mode;
            send_word(w, directed_rows[row].typed, want);
        end

        // Each random phase has its own setting and one of these idling patterns:
        // no idling, sender gaps, receiver stalls, and both sides rarely.
        // The extremes appear as a pause of 0 and 255, max_play of 0 and 255,
        // and a track limit of 0 and 15.
        run_phase(0,   255, 8,  0, 0,  0,  240);
        run_phase(2,   3,   5,  1, 48, 0,  220);
        run_phase(255, 1,   15, 0, 0,  48, 300);
        run_phase(1,   0,   0,  1, 6,  6,  120);
        run_phase(3,   255, 8,  0, 0,  0,  160);

        // The watchdog catches any result that never arrives.
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
